@@ design/rpn_pkg.sv @@
`default_nettype none

package rpn_pkg;

    localparam int DATA_W = 48;
    localparam int MAG_W  = 80;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int FRAC_DIGITS_DEF = 6;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(48'h7FFF_FFFF_FFFF);
    localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(48'h8000_0000_0000);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_BAD   = 1'b1;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NUM, OP_OUT
    } t_op;

    // saturating sign/magnitude to 48-bit two's complement
    function automatic logic [DATA_W-1:0] make_signed(input logic neg,
                                                      input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0] m;
        m = mag;
        if (neg) begin
            if (m > NEG_LIM) m = NEG_LIM;
            return DATA_W'(MAG_W'(0) - m);
        end
        if (m > POS_LIM) m = POS_LIM;
        return m[DATA_W-1:0];
    endfunction

    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] p;
        case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ design/rpn_calculator_stack_machine.sv @@
`default_nettype none

// channel | valid       | stall        | payload
// --------+-------------+--------------+------------------------------------
// in      | i_in_valid  | o_in_stall   | i_ch
// out     | o_out_valid | i_out_stall  | o_kind, o_value, o_bad_char
//
// a digit or point inside a number, or a digit after a pending minus, is taken in idle;
// other characters go through the decode state; / by zero drops the divisor and keeps
// the dividend, % by a divisor with a zero integer part pushes zero; a character that
// ends a number or a pending minus is decoded after the push; * / % and the divide that
// ends a number share one add/subtract unit that iterates one bit a cycle
// reset (synchronous, active low) empties the stack and the number scanner;
// input stalls while busy, and while a result waits and the output is stalled

module rpn_calculator_stack_machine
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_ch,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_kind,
    output logic signed [DATA_W-1:0] o_value,
    output logic [7:0]              o_bad_char
);

    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int QW    = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHAR = 7'b0000010,
        S_POPB = 7'b0000100,
        S_POPA = 7'b0001000,
        S_EXEC = 7'b0010000,
        S_RUN  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    // number scanner modes
    typedef enum logic [3:0] {
        SCAN_IDLE  = 4'b0001,
        SCAN_MINUS = 4'b0010,
        SCAN_INT   = 4'b0100,
        SCAN_FRAC  = 4'b1000
    } t_scan;

    // stack storage, read data registered
    logic [DATA_W-1:0] r_stack [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd;

    t_state            r_state, n_state;
    t_scan             r_scan, n_scan;
    t_op               r_op, n_op;
    logic [CW-1:0]     r_count, n_count;
    logic [7:0]        r_ch, n_ch;
    logic              r_again, n_again;
    logic [31:0]       r_iacc, n_iacc;
    logic [19:0]       r_facc, n_facc;
    logic [2:0]        r_fcnt, n_fcnt;
    logic              r_nneg, n_nneg;
    logic              r_bempty, n_bempty;
    logic              r_aempty, n_aempty;
    logic [DATA_W-1:0] r_b, n_b;
    logic              r_neg, n_neg;
    logic [DATA_W:0]   r_rem, n_rem;
    logic [QW-1:0]     r_quo, n_quo;
    logic [DATA_W-1:0] r_dvs, n_dvs;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ovalid, n_ovalid;
    logic              r_kind, n_kind;
    logic [DATA_W-1:0] r_value, n_value;
    logic [7:0]        r_bad, n_bad;

    logic              push_en;
    logic [DATA_W-1:0] push_val;
    logic [AW-1:0]     rd_addr;
    logic              accept;

    // operand views
    logic [DATA_W-1:0] a_v, ma, mb, b_pop;
    logic [DATA_W:0]   addsub;
    logic [DATA_W-1:0] addsub_sat;

    // shared add/subtract unit
    logic              u_sub;
    logic [DATA_W:0]   u_x;
    logic [DATA_W+1:0] u_sum;
    logic [DATA_W:0]   u_mul_sum;

    // number scanner helpers
    logic              in_digit, ch_digit;
    logic [3:0]        in_d, ch_d;
    logic [35:0]       iacc_x10;
    logic [23:0]       facc_x10;

    // result shaping
    logic [2*DATA_W-1:0] prod;
    logic [2*DATA_W-1:0] prod_sh;
    logic [19:0]         p10;
    t_state              after_op;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || (r_ovalid && i_out_stall);
    assign o_out_valid = r_ovalid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_bad_char  = r_bad;

    assign rd_addr = AW'(r_count - CW'(1));

    assign in_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign in_d     = 4'(i_ch - CH_ZERO);
    assign ch_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign ch_d     = 4'(r_ch - CH_ZERO);
    assign iacc_x10 = {r_iacc, 3'b000} + {3'b000, r_iacc, 1'b0} + 36'(in_d);
    assign facc_x10 = {r_facc, 3'b000} + {3'b000, r_facc, 1'b0} + 24'(in_d);

    // empty pops read as zero
    assign b_pop = r_bempty ? '0 : r_rd;
    assign a_v   = r_aempty ? '0 : r_rd;
    assign ma    = a_v[DATA_W-1] ? DATA_W'(-a_v) : a_v;
    assign mb    = r_b[DATA_W-1] ? DATA_W'(-r_b) : r_b;

    assign addsub = (r_op == OP_SUB)
                  ? {a_v[DATA_W-1], a_v} - {r_b[DATA_W-1], r_b}
                  : {a_v[DATA_W-1], a_v} + {r_b[DATA_W-1], r_b};
    assign addsub_sat = (addsub[DATA_W] != addsub[DATA_W-1])
                      ? (addsub[DATA_W] ? NEG_LIM[DATA_W-1:0] : POS_LIM[DATA_W-1:0])
                      : addsub[DATA_W-1:0];

    // divide: shift in next dividend bit, trial subtract; multiply: add
    assign u_sub     = (r_op != OP_MUL);
    assign u_x       = u_sub ? {r_rem[DATA_W-1:0], r_quo[QW-1]} : r_rem;
    assign u_sum     = (DATA_W+2)'(u_x)
                     + (u_sub ? ~(DATA_W+2)'(r_dvs) : (DATA_W+2)'(r_dvs))
                     + (DATA_W+2)'(u_sub);
    assign u_mul_sum = r_quo[0] ? u_sum[DATA_W:0] : r_rem;

    assign prod     = {r_rem[DATA_W-1:0], r_quo[DATA_W-1:0]};
    assign prod_sh  = prod >> FRAC_BITS;
    assign p10      = pow10(r_fcnt);
    assign after_op = r_again ? S_CHAR : S_IDLE;

    always_comb begin
        n_state  = r_state;
        n_scan   = r_scan;
        n_op     = r_op;
        n_count  = r_count;
        n_ch     = r_ch;
        n_again  = r_again;
        n_iacc   = r_iacc;
        n_facc   = r_facc;
        n_fcnt   = r_fcnt;
        n_nneg   = r_nneg;
        n_bempty = r_bempty;
        n_aempty = r_aempty;
        n_b      = r_b;
        n_neg    = r_neg;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid && i_out_stall;
        n_kind   = r_kind;
        n_value  = r_value;
        n_bad    = r_bad;
        push_en  = 1'b0;
        push_val = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ch = i_ch;
                    unique case (r_scan) inside
                        SCAN_MINUS: begin
                            if (in_digit) begin
                                n_scan = SCAN_INT;
                                n_nneg = 1'b1;
                                n_iacc = 32'(in_d);
                                n_facc = '0;
                                n_fcnt = '0;
                            end else begin
                                // minus not followed by a digit subtracts
                                n_scan  = SCAN_IDLE;
                                n_op    = OP_SUB;
                                n_again = 1'b1;
                                n_state = S_POPB;
                            end
                        end
                        SCAN_INT, SCAN_FRAC: begin
                            if (in_digit && r_scan == SCAN_INT) begin
                                n_iacc = (iacc_x10 > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : iacc_x10[31:0];
                            end else if (in_digit) begin
                                if (r_fcnt < 3'(FRAC_DIGITS)) begin
                                    n_facc = facc_x10[19:0];
                                    n_fcnt = r_fcnt + 3'd1;
                                end
                            end else if (i_ch == CH_DOT && r_scan == SCAN_INT) begin
                                n_scan = SCAN_FRAC;
                            end else begin
                                // number ends: rounded fraction divide
                                n_scan  = SCAN_IDLE;
                                n_op    = OP_NUM;
                                n_again = 1'b1;
                                n_rem   = '0;
                                n_quo   = (QW'(r_facc) << FRAC_BITS) + QW'(p10 >> 1);
                                n_dvs   = DATA_W'(p10);
                                n_cnt   = CNT_W'(QW);
                                n_neg   = r_nneg;
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                            n_state = S_CHAR;
                        end
                    endcase
                end
            end

            S_CHAR: begin
                n_again = 1'b0;
                n_state = S_IDLE;
                if (ch_digit) begin
                    n_scan = SCAN_INT;
                    n_nneg = 1'b0;
                    n_iacc = 32'(ch_d);
                    n_facc = '0;
                    n_fcnt = '0;
                end else begin
                    unique case (r_ch) inside
                        CH_SPACE, CH_TAB: ;
                        CH_DOT: begin
                            n_scan = SCAN_FRAC;
                            n_nneg = 1'b0;
                            n_iacc = '0;
                            n_facc = '0;
                            n_fcnt = '0;
                        end
                        CH_MINUS: n_scan = SCAN_MINUS;
                        CH_PLUS: begin
                            n_op    = OP_ADD;
                            n_state = S_POPB;
                        end
                        CH_STAR: begin
                            n_op    = OP_MUL;
                            n_state = S_POPB;
                        end
                        CH_SLASH: begin
                            n_op    = OP_DIV;
                            n_state = S_POPB;
                        end
                        CH_PCT: begin
                            n_op    = OP_MOD;
                            n_state = S_POPB;
                        end
                        CH_NL: begin
                            n_op    = OP_OUT;
                            n_state = S_POPB;
                        end
                        default: begin
                            n_ovalid = 1'b1;
                            n_kind   = KIND_BAD;
                            n_value  = '0;
                            n_bad    = r_ch;
                        end
                    endcase
                end
            end

            S_POPB: begin
                n_bempty = (r_count == '0);
                if (r_count != '0) n_count = r_count - CW'(1);
                n_state = S_POPA;
            end

            S_POPA: begin
                n_b = b_pop;
                if (r_op == OP_OUT) begin
                    n_ovalid = 1'b1;
                    n_kind   = KIND_VALUE;
                    n_value  = b_pop;
                    n_bad    = '0;
                    n_state  = after_op;
                end else if (r_op == OP_DIV && b_pop == '0) begin
                    // zero divisor is dropped, dividend stays
                    n_state = after_op;
                end else begin
                    n_aempty = (r_count == '0);
                    if (r_count != '0) n_count = r_count - CW'(1);
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_rem   = '0;
                n_dvs   = mb;
                n_state = S_RUN;
                case (r_op) inside
                    OP_ADD, OP_SUB: begin
                        push_en  = 1'b1;
                        push_val = addsub_sat;
                        n_state  = after_op;
                    end
                    OP_MUL: begin
                        n_neg = a_v[DATA_W-1] ^ r_b[DATA_W-1];
                        n_quo = QW'(mb);
                        n_dvs = ma;
                        n_cnt = CNT_W'(DATA_W);
                    end
                    OP_DIV: begin
                        n_neg = a_v[DATA_W-1] ^ r_b[DATA_W-1];
                        n_quo = QW'(ma) << FRAC_BITS;
                        n_cnt = CNT_W'(QW);
                    end
                    default: begin
                        // modulo on truncated integer parts
                        n_neg = a_v[DATA_W-1];
                        n_quo = QW'(ma >> FRAC_BITS);
                        n_dvs = mb >> FRAC_BITS;
                        n_cnt = CNT_W'(QW);
                        if ((mb >> FRAC_BITS) == '0) begin
                            push_en  = 1'b1;
                            push_val = '0;
                            n_state  = after_op;
                        end
                    end
                endcase
            end

            S_RUN: begin
                if (r_op == OP_MUL) begin
                    n_rem = u_mul_sum >> 1;
                    n_quo = QW'({u_mul_sum[0], r_quo[DATA_W-1:1]});
                end else begin
                    n_rem = u_sum[DATA_W+1] ? u_x : u_sum[DATA_W:0];
                    n_quo = {r_quo[QW-2:0], !u_sum[DATA_W+1]};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) n_state = S_FIN;
            end

            S_FIN: begin
                push_en = 1'b1;
                case (r_op)
                    OP_MUL: begin
                        if ((r_rem[DATA_W-1:0] >> FRAC_BITS) != '0)
                            push_val = make_signed(r_neg, NEG_LIM + MAG_W'(1));
                        else
                            push_val = make_signed(r_neg, MAG_W'(prod_sh[DATA_W-1:0]));
                    end
                    OP_DIV:  push_val = make_signed(r_neg, MAG_W'(r_quo));
                    OP_MOD:  push_val = make_signed(r_neg,
                                                    MAG_W'(r_rem[DATA_W-1:0]) << FRAC_BITS);
                    default: push_val = make_signed(r_neg,
                                                    (MAG_W'(r_iacc) << FRAC_BITS)
                                                    + MAG_W'(r_quo));
                endcase
                n_state = after_op;
            end

            default: n_state = S_IDLE;
        endcase

        // push onto a full stack is ignored
        if (push_en && r_count < CW'(STACK_DEPTH)) n_count = r_count + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (push_en && r_count < CW'(STACK_DEPTH)) r_stack[r_count[AW-1:0]] <= push_val;
        r_rd <= r_stack[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_scan   <= SCAN_IDLE;
            r_count  <= '0;
            r_again  <= 1'b0;
            r_iacc   <= '0;
            r_facc   <= '0;
            r_fcnt   <= '0;
            r_nneg   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_count  <= n_count;
            r_again  <= n_again;
            r_iacc   <= n_iacc;
            r_facc   <= n_facc;
            r_fcnt   <= n_fcnt;
            r_nneg   <= n_nneg;
            r_ovalid <= n_ovalid;
        end
        r_op     <= n_op;
        r_ch     <= n_ch;
        r_bempty <= n_bempty;
        r_aempty <= n_aempty;
        r_b      <= n_b;
        r_neg    <= n_neg;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_dvs    <= n_dvs;
        r_cnt    <= n_cnt;
        r_kind   <= n_kind;
        r_value  <= n_value;
        r_bad    <= n_bad;
    end

endmodule

`default_nettype wire
